// ===== rtl/trdf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trdf_pkg
// Shared constants, codes and types of the rectangle and disk fill engine.
// ----------------------------------------------------------------------------
package trdf_pkg;

	localparam int DEF_MAX_HEIGHT   = 64;
	localparam int DEF_MAX_WIDTH    = 64;
	localparam int DEF_MAX_CHANNELS = 4;

	localparam int REQ_W      = 2;
	localparam int COORD_W    = 16;
	localparam int WORD_W     = 64;
	localparam int NUM_WORDS  = 4;
	localparam int VCNT_W     = 3;
	localparam int CHIDX_W    = 2;
	localparam int COUNT_W    = 13;
	localparam int DIM_W      = 7;
	localparam int CHN_W      = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;
	localparam int EXT_W      = 18;
	localparam int SQ_W       = 31;

	localparam logic [REQ_W-1:0] REQ_RECT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_DISK = 2'd1;
	localparam logic [REQ_W-1:0] REQ_READ = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_IMG_HEIGHT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMG_WIDTH     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

	localparam logic [DIM_W-1:0] RST_IMG_HEIGHT    = 7'd64;
	localparam logic [DIM_W-1:0] RST_IMG_WIDTH     = 7'd64;
	localparam logic [CHN_W-1:0] RST_CHANNEL_COUNT = 3'd1;

	typedef struct packed {
		logic [REQ_W-1:0]                   req_type;
		logic signed [COORD_W-1:0]          row_a;
		logic signed [COORD_W-1:0]          col_a;
		logic signed [COORD_W-1:0]          row_b;
		logic signed [COORD_W-1:0]          col_b;
		logic signed [COORD_W-1:0]          radius;
		logic [NUM_WORDS-1:0][WORD_W-1:0]   fill_words;
		logic [VCNT_W-1:0]                  value_count;
		logic [CHIDX_W-1:0]                 channel_index;
	} req_t;

	typedef struct packed {
		logic [WORD_W-1:0]  read_value;
		logic [COUNT_W-1:0] pixels_written;
		logic               status;
	} res_t;

	typedef struct packed {
		logic load;
		logic bounds;
		logic mul_r;
		logic mul_y;
		logic mul_x;
		logic scan;
		logic rd;
		logic res_load;
		logic clr;
	} cmd_t;

	typedef struct packed {
		logic skip;
		logic is_read;
		logic scan_last;
		logic clr_last;
	} sts_t;

endpackage

// ===== rtl/trdf_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trdf_if
// Channel interfaces: request, result and configuration write.
// ----------------------------------------------------------------------------
interface trdf_req_if;
	import trdf_pkg::*;
	logic                         valid;
	logic                         ready;
	logic [REQ_W-1:0]             req_type;
	logic signed [COORD_W-1:0]    row_a;
	logic signed [COORD_W-1:0]    col_a;
	logic signed [COORD_W-1:0]    row_b;
	logic signed [COORD_W-1:0]    col_b;
	logic signed [COORD_W-1:0]    radius;
	logic [WORD_W-1:0]            fill_value_0;
	logic [WORD_W-1:0]            fill_value_1;
	logic [WORD_W-1:0]            fill_value_2;
	logic [WORD_W-1:0]            fill_value_3;
	logic [VCNT_W-1:0]            value_count;
	logic [CHIDX_W-1:0]           channel_index;

	modport source (output valid, req_type, row_a, col_a, row_b, col_b, radius,
		fill_value_0, fill_value_1, fill_value_2, fill_value_3, value_count,
		channel_index, input ready);
	modport sink (input valid, req_type, row_a, col_a, row_b, col_b, radius,
		fill_value_0, fill_value_1, fill_value_2, fill_value_3, value_count,
		channel_index, output ready);
endinterface

interface trdf_res_if;
	import trdf_pkg::*;
	logic               valid;
	logic               ready;
	logic [WORD_W-1:0]  read_value;
	logic [COUNT_W-1:0] pixels_written;
	logic               status;

	modport source (output valid, read_value, pixels_written, status, input ready);
	modport sink (input valid, read_value, pixels_written, status, output ready);
endinterface

interface trdf_cfg_if;
	import trdf_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/trdf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trdf_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module trdf_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

// ===== rtl/trdf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trdf_ctrl
// Sequencer: clearing pass, setup steps, pixel scan, read and result hand-off.
// ----------------------------------------------------------------------------
module trdf_ctrl import trdf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [8:0] {
		ST_CLEAR  = 9'b000000001,
		ST_IDLE   = 9'b000000010,
		ST_BOUNDS = 9'b000000100,
		ST_MUL_R  = 9'b000001000,
		ST_MUL_Y  = 9'b000010000,
		ST_MUL_X  = 9'b000100000,
		ST_SCAN   = 9'b001000000,
		ST_RD     = 9'b010000000,
		ST_FINISH = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_BOUNDS;
				end
			end
			ST_BOUNDS: begin
				cmd.bounds = 1'b1;
				state_d    = ST_MUL_R;
			end
			ST_MUL_R: begin
				cmd.mul_r = 1'b1;
				if (sts.skip) state_d = ST_FINISH;
				else if (sts.is_read) state_d = ST_RD;
				else state_d = ST_MUL_Y;
			end
			ST_MUL_Y: begin
				cmd.mul_y = 1'b1;
				state_d   = ST_MUL_X;
			end
			ST_MUL_X: begin
				cmd.mul_x = 1'b1;
				state_d   = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last) state_d = ST_FINISH;
			end
			ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.res_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/trdf_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trdf_dp
// Datapath: config registers, bound clamping, squares, scan counters, store.
// ----------------------------------------------------------------------------
module trdf_dp import trdf_pkg::*; #(
	parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
	parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
	parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  req_t                  req,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	output res_t                  res
);

	localparam int DEPTH = MAX_HEIGHT * MAX_WIDTH * MAX_CHANNELS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int RW    = $clog2(MAX_HEIGHT + 1);
	localparam int CW    = $clog2(MAX_WIDTH + 1);
	localparam int PIXW  = $clog2(MAX_HEIGHT * MAX_WIDTH + 1);
	localparam int MW    = PIXW + CHN_W;

	// config registers
	logic [DIM_W-1:0] img_height_q, img_width_q;
	logic [CHN_W-1:0] channel_count_q;
	logic [RW-1:0]    h_eff;
	logic [CW-1:0]    w_eff;
	logic [CHN_W-1:0] ch_eff;

	// request and setup registers
	req_t                    req_q;
	logic                    skip_q, is_read_q, is_rect_q;
	logic [RW-1:0]           y0_q, y1_q, y_q;
	logic [CW-1:0]           x0_q, x1_q, x_q;
	logic signed [EXT_W-1:0] dy0_q, dx0_q, dy_q, dx_q;
	logic [SQ_W-1:0]         r2_q, dysq_q, dxsq_q, dx0sq_q;
	logic [PIXW-1:0]         pix_q, row_pix_q;
	logic [CHIDX_W-1:0]      c_q;
	logic [COUNT_W-1:0]      cnt_q;
	logic [AW-1:0]           clr_q;
	res_t                    res_q;

	// bounds
	logic signed [EXT_W-1:0] ra, ca, rb, cb, rr, hs, ws;
	logic signed [EXT_W-1:0] lo_y, hi_y, lo_x, hi_x, y0c, y1c, x0c, x1c;
	logic                    box_empty, in_range, skip_d;

	// squares and scan
	logic signed [EXT_W-1:0]   sq_in;
	logic signed [2*EXT_W-1:0] sq_prod;
	logic [PIXW-1:0]           pix0, row_pix_nx;
	logic [SQ_W:0]             dist_sq;
	logic                      in_disk, broadcast, more_ch, scan_wr, x_end, y_end;
	logic [VCNT_W-1:0]         nwr, c_inc;
	logic [CW-1:0]             x_nx;
	logic [RW-1:0]             y_nx;
	logic signed [31:0]        dxsq_sum, dysq_sum;

	// store port
	logic [CHIDX_W-1:0] c_sel;
	logic [MW-1:0]      addr_full;
	logic               ram_en, ram_we;
	logic [AW-1:0]      ram_addr;
	logic [WORD_W-1:0]  ram_wdata, ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_height_q    <= RST_IMG_HEIGHT;
			img_width_q     <= RST_IMG_WIDTH;
			channel_count_q <= RST_CHANNEL_COUNT;
			clr_q           <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_IMG_HEIGHT:    img_height_q    <= cfg_data;
					REG_IMG_WIDTH:     img_width_q     <= cfg_data;
					REG_CHANNEL_COUNT: channel_count_q <= CHN_W'(cfg_data);
					default: ;
				endcase
			end
			if (cmd.clr) clr_q <= clr_q + AW'(1);
		end
	end

	assign h_eff = (32'(img_height_q) > MAX_HEIGHT) ? RW'(MAX_HEIGHT) : RW'(img_height_q);
	assign w_eff = (32'(img_width_q) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(img_width_q);
	assign ch_eff = (channel_count_q == '0) ? CHN_W'(1) :
		(32'(channel_count_q) > MAX_CHANNELS) ? CHN_W'(MAX_CHANNELS) : channel_count_q;

	// bound clamping
	assign ra = EXT_W'(req_q.row_a);
	assign ca = EXT_W'(req_q.col_a);
	assign rb = EXT_W'(req_q.row_b);
	assign cb = EXT_W'(req_q.col_b);
	assign rr = EXT_W'(req_q.radius);
	assign hs = $signed(EXT_W'(h_eff));
	assign ws = $signed(EXT_W'(w_eff));

	always_comb begin
		if (req_q.req_type == REQ_RECT) begin
			lo_y = (ra < rb) ? ra : rb;
			hi_y = (ra < rb) ? rb : ra;
			lo_x = (ca < cb) ? ca : cb;
			hi_x = (ca < cb) ? cb : ca;
		end else begin
			lo_y = ra - rr;
			hi_y = ra + rr + EXT_W'(1);
			lo_x = ca - rr;
			hi_x = ca + rr + EXT_W'(1);
		end
		y0c = lo_y[EXT_W-1] ? '0 : lo_y;
		x0c = lo_x[EXT_W-1] ? '0 : lo_x;
		y1c = (hi_y > hs) ? hs : hi_y;
		x1c = (hi_x > ws) ? ws : hi_x;
		box_empty = (y0c >= y1c) || (x0c >= x1c);
		in_range = !ra[EXT_W-1] && (ra < hs) && !ca[EXT_W-1] && (ca < ws) &&
			({1'b0, req_q.channel_index} < ch_eff);
		case (req_q.req_type)
			REQ_RECT: skip_d = box_empty;
			REQ_DISK: skip_d = rr[EXT_W-1] || box_empty;
			REQ_READ: skip_d = !in_range;
			default:  skip_d = 1'b1;
		endcase
	end

	// shared squaring multiplier
	always_comb begin
		if (cmd.mul_r) sq_in = rr;
		else if (cmd.mul_y) sq_in = dy0_q;
		else sq_in = dx0_q;
	end
	assign sq_prod = sq_in * sq_in;
	assign pix0 = PIXW'(PIXW'(y0_q) * PIXW'(w_eff)) + PIXW'(x0_q);

	// pixel scan
	assign dist_sq    = {1'b0, dxsq_q} + {1'b0, dysq_q};
	assign in_disk    = is_rect_q || (dist_sq <= {1'b0, r2_q});
	assign broadcast  = (req_q.value_count == VCNT_W'(1)) && (ch_eff > CHN_W'(1));
	assign nwr = broadcast ? ch_eff :
		((req_q.value_count < ch_eff) ? req_q.value_count : ch_eff);
	assign c_inc      = {1'b0, c_q} + VCNT_W'(1);
	assign more_ch    = in_disk && (c_inc < nwr);
	assign scan_wr    = cmd.scan && in_disk && ({1'b0, c_q} < nwr);
	assign x_nx       = x_q + CW'(1);
	assign y_nx       = y_q + RW'(1);
	assign x_end      = (x_nx == x1_q);
	assign y_end      = (y_nx == y1_q);
	assign row_pix_nx = row_pix_q + PIXW'(w_eff);
	assign dxsq_sum   = $signed({1'b0, dxsq_q}) + 32'(dx_q <<< 1) + 32'sd1;
	assign dysq_sum   = $signed({1'b0, dysq_q}) + 32'(dy_q <<< 1) + 32'sd1;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
			cnt_q <= '0;
		end
		if (cmd.bounds) begin
			skip_q    <= skip_d;
			is_read_q <= (req_q.req_type == REQ_READ);
			is_rect_q <= (req_q.req_type == REQ_RECT);
			y0_q      <= (req_q.req_type == REQ_READ) ? RW'(ra) : RW'(y0c);
			x0_q      <= (req_q.req_type == REQ_READ) ? CW'(ca) : CW'(x0c);
			y1_q      <= RW'(y1c);
			x1_q      <= CW'(x1c);
			dy0_q     <= y0c - ra;
			dx0_q     <= x0c - ca;
		end
		if (cmd.mul_r) begin
			r2_q      <= sq_prod[SQ_W-1:0];
			pix_q     <= pix0;
			row_pix_q <= pix0;
		end
		if (cmd.mul_y) begin
			dysq_q <= sq_prod[SQ_W-1:0];
			dy_q   <= dy0_q;
			y_q    <= y0_q;
		end
		if (cmd.mul_x) begin
			dx0sq_q <= sq_prod[SQ_W-1:0];
			dxsq_q  <= sq_prod[SQ_W-1:0];
			dx_q    <= dx0_q;
			x_q     <= x0_q;
			c_q     <= '0;
		end
		if (cmd.scan) begin
			if (more_ch) begin
				c_q <= c_q + CHIDX_W'(1);
			end else begin
				c_q <= '0;
				if (in_disk) cnt_q <= cnt_q + COUNT_W'(1);
				if (!x_end) begin
					x_q    <= x_nx;
					pix_q  <= pix_q + PIXW'(1);
					dx_q   <= dx_q + EXT_W'(1);
					dxsq_q <= dxsq_sum[SQ_W-1:0];
				end else begin
					x_q       <= x0_q;
					dx_q      <= dx0_q;
					dxsq_q    <= dx0sq_q;
					y_q       <= y_nx;
					row_pix_q <= row_pix_nx;
					pix_q     <= row_pix_nx;
					dy_q      <= dy_q + EXT_W'(1);
					dysq_q    <= dysq_sum[SQ_W-1:0];
				end
			end
		end
		if (cmd.res_load) begin
			res_q.read_value     <= (is_read_q && !skip_q) ? ram_rdata : '0;
			res_q.pixels_written <= cnt_q;
			res_q.status         <= is_read_q && skip_q;
		end
	end

	// element store
	assign c_sel     = cmd.rd ? req_q.channel_index : c_q;
	assign addr_full = MW'(pix_q) * MW'(ch_eff) + MW'(c_sel);
	assign ram_en    = cmd.clr || scan_wr || cmd.rd;
	assign ram_we    = cmd.clr || scan_wr;
	assign ram_addr  = cmd.clr ? clr_q : AW'(addr_full);
	assign ram_wdata = cmd.clr ? '0 :
		(broadcast ? req_q.fill_words[0] : req_q.fill_words[c_q]);

	trdf_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign sts.skip      = skip_q;
	assign sts.is_read   = is_read_q;
	assign sts.scan_last = !more_ch && x_end && y_end;
	assign sts.clr_last  = (clr_q == AW'(DEPTH - 1));
	assign res           = res_q;

endmodule

// ===== rtl/tensor_rect_disk_fill_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tensor_rect_disk_fill_top
// Rectangle and disk fill engine with element read over a 64-bit word store.
// ----------------------------------------------------------------------------
//  channel  dir  beat contents
//  cfg      in   register index, 7-bit data (ready always high)
//  req      in   request type, corners or centre, radius, fill words, counts
//  res      out  read word, pixels counted, read status
//
//  a fill runs the bounds and squaring steps, then scans, writing each word in
//  turn through the single store port; a pixel with no word still takes a scan
//  step; a read reads its word after the radius step; skipped requests go straight to the result
//  after reset a clearing pass writes zero to all MAX_HEIGHT*MAX_WIDTH*
//  MAX_CHANNELS words before the first request beat
//  a finished result sits in an output register; a new request is taken
//  while it waits, and the next result is held back until it is taken
// ----------------------------------------------------------------------------
module tensor_rect_disk_fill_top import trdf_pkg::*; #(
	parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
	parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
	parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
	input  logic       clk,
	input  logic       arst_n,
	trdf_cfg_if.sink   cfg,
	trdf_req_if.sink   req,
	trdf_res_if.source res
);

	req_t req_s;
	res_t res_s;
	cmd_t cmd;
	sts_t sts;

	assign cfg.ready = 1'b1;

	assign req_s.req_type      = req.req_type;
	assign req_s.row_a         = req.row_a;
	assign req_s.col_a         = req.col_a;
	assign req_s.row_b         = req.row_b;
	assign req_s.col_b         = req.col_b;
	assign req_s.radius        = req.radius;
	assign req_s.fill_words[0] = req.fill_value_0;
	assign req_s.fill_words[1] = req.fill_value_1;
	assign req_s.fill_words[2] = req.fill_value_2;
	assign req_s.fill_words[3] = req.fill_value_3;
	assign req_s.value_count   = req.value_count;
	assign req_s.channel_index = req.channel_index;

	assign res.read_value     = res_s.read_value;
	assign res.pixels_written = res_s.pixels_written;
	assign res.status         = res_s.status;

	trdf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	trdf_dp #(
		.MAX_HEIGHT   (MAX_HEIGHT),
		.MAX_WIDTH    (MAX_WIDTH),
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg.valid),
		.cfg_idx  (cfg.index),
		.cfg_data (cfg.data),
		.req      (req_s),
		.cmd      (cmd),
		.sts      (sts),
		.res      (res_s)
	);

endmodule
